// ===== rtl/kscm_pkg.sv =====
// ---------------------------------------------------------------------------
// kscm_pkg
// Shared types and constants of the key and switch command mapper.
// ---------------------------------------------------------------------------
package kscm_pkg;

  localparam int MAX_ENTRIES = 8;
  localparam int IDX_W       = 3;
  localparam int SW_W        = 2;
  localparam int MAX_KEY_W   = 16;
  localparam int ENTRY_W     = 23;

  // map entry register layout
  localparam int LSW_LSB  = 16;
  localparam int RSW_LSB  = 18;
  localparam int MODE_LSB = 20;
  localparam int EN_BIT   = 22;

  localparam logic [SW_W-1:0] SW_ANY = 2'd0;

  typedef enum logic [1:0] {
    MODE_PRESS  = 2'd0,
    MODE_HOLD   = 2'd1,
    MODE_REPEAT = 2'd2,
    MODE_TOGGLE = 2'd3
  } mode_t;

  typedef enum logic {
    ACT_ADD    = 1'b0,
    ACT_REMOVE = 1'b1
  } action_t;

  // action offered by the cell holding the request token
  typedef struct packed {
    logic    vld;
    action_t action;
  } cell_act_t;

endpackage

// ===== rtl/kscm_if.sv =====
// ---------------------------------------------------------------------------
// kscm_if
// Valid/ready channels of the command mapper: snapshot requests, actions
// and map entry writes.
// ---------------------------------------------------------------------------
interface kscm_in_if;
  logic                             valid;
  logic                             ready;
  logic [kscm_pkg::MAX_KEY_W-1:0]   key_bits;
  logic [kscm_pkg::SW_W-1:0]        left_sw;
  logic [kscm_pkg::SW_W-1:0]        right_sw;
  logic [kscm_pkg::MAX_ENTRIES-1:0] scheduled_mask;

  modport source (output valid, key_bits, left_sw, right_sw, scheduled_mask,
                  input ready);
  modport sink (input valid, key_bits, left_sw, right_sw, scheduled_mask,
                output ready);
endinterface

interface kscm_out_if;
  logic                       valid;
  logic                       ready;
  logic [kscm_pkg::IDX_W-1:0] entry_index;
  logic                       action;
  logic                       last;

  modport source (output valid, entry_index, action, last, input ready);
  modport sink (input valid, entry_index, action, last, output ready);
endinterface

interface kscm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [kscm_pkg::IDX_W-1:0]   index;
  logic [kscm_pkg::ENTRY_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/kscm_cell.sv =====
// ---------------------------------------------------------------------------
// kscm_cell
// One map entry: holds its configuration and pressed/toggled flags, checks
// the snapshot when the request token sits here and passes it on.
// ---------------------------------------------------------------------------
module kscm_cell #(
  parameter int CELL_IDX = 0,
  parameter int KEY_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              shift,
  input  logic                              tok_i,
  input  logic [KEY_BITS-1:0]               keys_i,
  input  logic [kscm_pkg::SW_W-1:0]         lsw_i,
  input  logic [kscm_pkg::SW_W-1:0]         rsw_i,
  input  logic [kscm_pkg::MAX_ENTRIES-1:0]  sched_i,
  input  logic                              cfg_we,
  input  logic [kscm_pkg::ENTRY_W-1:0]      cfg_data,
  output logic                              tok_o,
  output logic [KEY_BITS-1:0]               keys_o,
  output logic [kscm_pkg::SW_W-1:0]         lsw_o,
  output logic [kscm_pkg::SW_W-1:0]         rsw_o,
  output logic [kscm_pkg::MAX_ENTRIES-1:0]  sched_o,
  output kscm_pkg::cell_act_t               act_o
);

  logic                             tok_r;
  logic [KEY_BITS-1:0]              keys_r;
  logic [kscm_pkg::SW_W-1:0]        lsw_r;
  logic [kscm_pkg::SW_W-1:0]        rsw_r;
  logic [kscm_pkg::MAX_ENTRIES-1:0] sched_r;

  logic [KEY_BITS-1:0]              kmask_r;
  logic [kscm_pkg::SW_W-1:0]        lpat_r;
  logic [kscm_pkg::SW_W-1:0]        rpat_r;
  kscm_pkg::mode_t                  mode_r;
  logic                             en_r;
  logic                             pressed_r;
  logic                             toggled_r;
  logic                             pressed_nxt;
  logic                             toggled_nxt;

  logic                             match;
  logic                             act_vld;
  kscm_pkg::action_t                act_kind;
  logic                             eval;

  assign match = (lpat_r == kscm_pkg::SW_ANY || lpat_r == lsw_r) &&
                 (rpat_r == kscm_pkg::SW_ANY || rpat_r == rsw_r) &&
                 ((keys_r & kmask_r) == kmask_r);

  always_comb begin
    act_vld     = 1'b0;
    act_kind    = kscm_pkg::ACT_ADD;
    pressed_nxt = pressed_r;
    toggled_nxt = toggled_r;
    if (match) begin
      case (mode_r)
        kscm_pkg::MODE_PRESS, kscm_pkg::MODE_HOLD: begin
          if (!pressed_r) begin
            act_vld     = 1'b1;
            pressed_nxt = 1'b1;
          end
        end
        kscm_pkg::MODE_REPEAT: begin
          act_vld = !sched_r[CELL_IDX];
        end
        kscm_pkg::MODE_TOGGLE: begin
          if (!pressed_r) begin
            act_vld     = 1'b1;
            act_kind    = toggled_r ? kscm_pkg::ACT_REMOVE : kscm_pkg::ACT_ADD;
            toggled_nxt = !toggled_r;
            pressed_nxt = 1'b1;
          end
        end
        default: begin
          act_vld = 1'b0;
        end
      endcase
    end else begin
      // released: hold drops its command, hold-repeat always asks for removal
      if ((mode_r == kscm_pkg::MODE_HOLD && pressed_r) ||
          mode_r == kscm_pkg::MODE_REPEAT) begin
        act_vld  = 1'b1;
        act_kind = kscm_pkg::ACT_REMOVE;
      end
      pressed_nxt = 1'b0;
    end
  end

  assign eval  = tok_r && en_r && shift;
  assign act_o = kscm_pkg::cell_act_t'{vld: tok_r && en_r && act_vld, action: act_kind};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r     <= 1'b0;
      kmask_r   <= '0;
      lpat_r    <= '0;
      rpat_r    <= '0;
      mode_r    <= kscm_pkg::MODE_PRESS;
      en_r      <= 1'b0;
      pressed_r <= 1'b0;
      toggled_r <= 1'b0;
    end else begin
      if (shift) begin
        tok_r <= tok_i;
      end
      if (cfg_we) begin
        // a new mapping starts with fresh flags
        kmask_r   <= cfg_data[KEY_BITS-1:0];
        lpat_r    <= cfg_data[kscm_pkg::LSW_LSB +: kscm_pkg::SW_W];
        rpat_r    <= cfg_data[kscm_pkg::RSW_LSB +: kscm_pkg::SW_W];
        mode_r    <= kscm_pkg::mode_t'(cfg_data[kscm_pkg::MODE_LSB +: 2]);
        en_r      <= cfg_data[kscm_pkg::EN_BIT];
        pressed_r <= 1'b0;
        toggled_r <= 1'b0;
      end else if (eval) begin
        pressed_r <= pressed_nxt;
        toggled_r <= toggled_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      keys_r  <= keys_i;
      lsw_r   <= lsw_i;
      rsw_r   <= rsw_i;
      sched_r <= sched_i;
    end
  end

  assign tok_o   = tok_r;
  assign keys_o  = keys_r;
  assign lsw_o   = lsw_r;
  assign rsw_o   = rsw_r;
  assign sched_o = sched_r;

endmodule

// ===== rtl/key_switch_command_mapper.sv =====
// ---------------------------------------------------------------------------
// key_switch_command_mapper
// Maps remote key/switch snapshots to add/remove command actions through a
// chain of map entry cells.
// ---------------------------------------------------------------------------
// the request token walks the cell chain; each action is held in a pending register
//   and then in the output register; a new request is accepted only after the token
//   walk through the cell chain and the flush step, and output stalls hold the chain
// reset: synchronous, clears all map entries, pressed and toggled flags
// ---------------------------------------------------------------------------
module key_switch_command_mapper #(
  parameter int NUM_ENTRIES = 8,
  parameter int KEY_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  kscm_in_if.sink     in_req,
  kscm_out_if.source  out_res,
  kscm_cfg_if.sink    cfg_wr
);

  localparam int IDX_W = kscm_pkg::IDX_W;

  logic                             chain_tok   [NUM_ENTRIES+1];
  logic [KEY_BITS-1:0]              chain_keys  [NUM_ENTRIES+1];
  logic [kscm_pkg::SW_W-1:0]        chain_lsw   [NUM_ENTRIES+1];
  logic [kscm_pkg::SW_W-1:0]        chain_rsw   [NUM_ENTRIES+1];
  logic [kscm_pkg::MAX_ENTRIES-1:0] chain_sched [NUM_ENTRIES+1];
  kscm_pkg::cell_act_t              cell_act    [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0]           tok_vec;

  logic                 busy_r;
  logic                 fin_r;
  logic                 fin_nxt;
  logic                 pend_vld_r;
  logic [IDX_W-1:0]     pend_idx_r;
  kscm_pkg::action_t    pend_act_r;
  logic                 out_vld_r;
  logic [IDX_W-1:0]     out_idx_r;
  kscm_pkg::action_t    out_act_r;
  logic                 out_last_r;

  logic                 load;
  logic                 act_any;
  logic [IDX_W-1:0]     act_idx;
  kscm_pkg::action_t    act_kind;
  logic                 out_free;
  logic                 shift;
  logic                 fin_done;
  logic                 push;

  assign in_req.ready = !busy_r;
  assign cfg_wr.ready = 1'b1;
  assign load         = in_req.valid && !busy_r;

  assign chain_tok[0]   = load;
  assign chain_keys[0]  = in_req.key_bits[KEY_BITS-1:0];
  assign chain_lsw[0]   = in_req.left_sw;
  assign chain_rsw[0]   = in_req.right_sw;
  assign chain_sched[0] = in_req.scheduled_mask;

  for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
    kscm_cell #(
      .CELL_IDX (g),
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift    (shift),
      .tok_i    (chain_tok[g]),
      .keys_i   (chain_keys[g]),
      .lsw_i    (chain_lsw[g]),
      .rsw_i    (chain_rsw[g]),
      .sched_i  (chain_sched[g]),
      .cfg_we   (cfg_wr.valid && cfg_wr.index == IDX_W'(g)),
      .cfg_data (cfg_wr.data),
      .tok_o    (chain_tok[g+1]),
      .keys_o   (chain_keys[g+1]),
      .lsw_o    (chain_lsw[g+1]),
      .rsw_o    (chain_rsw[g+1]),
      .sched_o  (chain_sched[g+1]),
      .act_o    (cell_act[g])
    );
    assign tok_vec[g] = chain_tok[g+1];
  end

  // only the token holder can offer an action
  always_comb begin
    act_any  = 1'b0;
    act_idx  = '0;
    act_kind = kscm_pkg::ACT_ADD;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (cell_act[i].vld) begin
        act_any  = 1'b1;
        act_idx  = IDX_W'(i);
        act_kind = cell_act[i].action;
      end
    end
  end

  // a new action pushes the held one out with last clear; the flush step
  // sends the held one with last set
  assign out_free = !out_vld_r || out_res.ready;
  assign shift    = !(act_any && pend_vld_r && !out_free);
  assign fin_done = fin_r && (!pend_vld_r || out_free);
  assign push     = (act_any && pend_vld_r && shift) || (fin_r && pend_vld_r && out_free);
  assign fin_nxt  = fin_r ? !fin_done : (shift && chain_tok[NUM_ENTRIES]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      fin_r      <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
      end else if (fin_done) begin
        busy_r <= 1'b0;
      end
      fin_r <= fin_nxt;
      if (act_any && shift) begin
        pend_vld_r <= 1'b1;
      end else if (fin_r && out_free) begin
        pend_vld_r <= 1'b0;
      end
      if (push) begin
        out_vld_r <= 1'b1;
      end else if (out_res.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (act_any && shift) begin
      pend_idx_r <= act_idx;
      pend_act_r <= act_kind;
    end
    if (push) begin
      out_idx_r  <= pend_idx_r;
      out_act_r  <= pend_act_r;
      out_last_r <= fin_r;
    end
  end

  assign out_res.valid       = out_vld_r;
  assign out_res.entry_index = out_idx_r;
  assign out_res.action      = out_act_r;
  assign out_res.last        = out_last_r;

  // a single request token lives in the chain or the flush step
  a_one_token : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({tok_vec, fin_r}))
    else $error("more than one request token in flight");

  // while idle nothing is held back or in flight
  a_idle_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (!pend_vld_r && tok_vec == '0 && !fin_r))
    else $error("idle with work outstanding");

  // a flush with nothing held frees the block at once
  a_flush_free : assert property (@(posedge clk) disable iff (!rst_n)
    (fin_r && !pend_vld_r) |=> !busy_r)
    else $error("flush did not release the block");

endmodule

// ===== sim/key_switch_command_mapper_tb.sv =====
// ---------------------------------------------------------------------------
// key_switch_command_mapper_tb
// Self-checking bench for the command mapper. Map entries are written over
// the config channel, remote snapshots are sent with random gaps and output
// stalls, and every action is checked against a local model of the entry
// flags. Directed cases come first, then phases of random maps and snapshots.
// ---------------------------------------------------------------------------
module key_switch_command_mapper_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ENTRIES   = kscm_pkg::MAX_ENTRIES;
  localparam int IDX_W         = kscm_pkg::IDX_W;
  localparam int SW_W          = kscm_pkg::SW_W;
  localparam int ENTRY_W       = kscm_pkg::ENTRY_W;
  localparam int LSW_LSB       = kscm_pkg::LSW_LSB;
  localparam int RSW_LSB       = kscm_pkg::RSW_LSB;
  localparam int MODE_LSB      = kscm_pkg::MODE_LSB;
  localparam int EN_BIT        = kscm_pkg::EN_BIT;
  localparam int SETTLE_CYCLES = 2 * (MAX_ENTRIES + 2);
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 32;

  typedef struct packed {
    logic [IDX_W-1:0]  entry_index;
    kscm_pkg::action_t action;
    logic              last;
  } action_rec_t;

  logic clk;
  logic rst_n;

  kscm_in_if  in_req();
  kscm_out_if out_res();
  kscm_cfg_if cfg_wr();

  key_switch_command_mapper #(
    .NUM_ENTRIES(8),
    .KEY_BITS   (16)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_res(out_res),
    .cfg_wr (cfg_wr)
  );

  // model of the map and its per-entry flags
  logic [ENTRY_W-1:0] map_entries [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] entry_pressed;
  logic [MAX_ENTRIES-1:0] entry_toggled;
  action_rec_t pending_actions[$];

  bit idle_on;
  int mismatches;
  int snapshots_sent;
  int actions_seen;
  int cfg_writes;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("key_switch_command_mapper_tb NOT OK");
    $finish;
  end

  function automatic logic [ENTRY_W-1:0] make_entry(input logic [15:0] keys,
                                                    input logic [SW_W-1:0] lpat,
                                                    input logic [SW_W-1:0] rpat,
                                                    input kscm_pkg::mode_t mode,
                                                    input logic en);
    return {en, mode, rpat, lpat, keys};
  endfunction

  // expected actions for one snapshot, in entry order
  task automatic predict_actions(input logic [15:0] keys, input logic [SW_W-1:0] lsw,
                                 input logic [SW_W-1:0] rsw,
                                 input logic [MAX_ENTRIES-1:0] sched);
    action_rec_t rec;
    action_rec_t found[$];
    logic [ENTRY_W-1:0] e;
    logic [SW_W-1:0] lpat;
    logic [SW_W-1:0] rpat;
    logic [15:0] kmask;
    kscm_pkg::mode_t mode;
    logic hit;
    logic emit;
    kscm_pkg::action_t act;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      e = map_entries[i];
      if (!e[EN_BIT]) continue;
      kmask = e[LSW_LSB-1:0];
      lpat  = e[LSW_LSB +: SW_W];
      rpat  = e[RSW_LSB +: SW_W];
      mode  = kscm_pkg::mode_t'(e[MODE_LSB +: 2]);
      hit   = (lpat == kscm_pkg::SW_ANY || lpat == lsw) &&
              (rpat == kscm_pkg::SW_ANY || rpat == rsw) &&
              ((keys & kmask) == kmask);
      emit  = 1'b0;
      act   = kscm_pkg::ACT_ADD;
      if (hit) begin
        case (mode)
          kscm_pkg::MODE_PRESS, kscm_pkg::MODE_HOLD: begin
            if (!entry_pressed[i]) begin
              entry_pressed[i] = 1'b1;
              emit = 1'b1;
            end
          end
          kscm_pkg::MODE_REPEAT: begin
            emit = !sched[i];
          end
          default: begin
            if (!entry_pressed[i]) begin
              act = entry_toggled[i] ? kscm_pkg::ACT_REMOVE : kscm_pkg::ACT_ADD;
              entry_toggled[i] = !entry_toggled[i];
              entry_pressed[i] = 1'b1;
              emit = 1'b1;
            end
          end
        endcase
      end else begin
        if ((mode == kscm_pkg::MODE_HOLD && entry_pressed[i]) ||
            mode == kscm_pkg::MODE_REPEAT) begin
          emit = 1'b1;
          act  = kscm_pkg::ACT_REMOVE;
        end
        entry_pressed[i] = 1'b0;
      end
      if (emit) begin
        rec.entry_index = i[IDX_W-1:0];
        rec.action      = act;
        rec.last        = 1'b0;
        found.push_back(rec);
      end
    end
    if (found.size() > 0) begin
      rec = found.pop_back();
      rec.last = 1'b1;
      found.push_back(rec);
    end
    foreach (found[k]) pending_actions.push_back(found[k]);
  endtask

  task automatic send_snapshot(input logic [15:0] keys, input logic [SW_W-1:0] lsw,
                               input logic [SW_W-1:0] rsw,
                               input logic [MAX_ENTRIES-1:0] sched);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_req.valid          <= 1'b1;
    in_req.key_bits       <= keys;
    in_req.left_sw        <= lsw;
    in_req.right_sw       <= rsw;
    in_req.scheduled_mask <= sched;
    do @(posedge clk); while (!in_req.ready);
    predict_actions(keys, lsw, rsw, sched);
    snapshots_sent++;
  endtask

  // drop valid, wait for every pending action, then let the entry chain drain
  task automatic settle();
    @(negedge clk);
    in_req.valid <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_entry(input int idx, input logic [ENTRY_W-1:0] data);
    @(negedge clk);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx[IDX_W-1:0];
    cfg_wr.data  <= data;
    do @(posedge clk); while (!cfg_wr.ready);
    map_entries[idx]   = data;
    entry_pressed[idx] = 1'b0;
    entry_toggled[idx] = 1'b0;
    cfg_writes++;
    @(negedge clk);
    cfg_wr.valid <= 1'b0;
  endtask

  function automatic logic [ENTRY_W-1:0] random_entry();
    logic [15:0] keys;
    logic [SW_W-1:0] lpat;
    logic [SW_W-1:0] rpat;
    case ($urandom_range(0, 9))
      0:       keys = '0;
      1:       keys = 16'hFFFF;
      2:       keys = 16'($urandom);
      default: keys = (16'd1 << $urandom_range(0, 15)) |
                      ($urandom_range(0, 1) ? (16'd1 << $urandom_range(0, 15)) : 16'd0);
    endcase
    lpat = $urandom_range(0, 1) ? kscm_pkg::SW_ANY : SW_W'($urandom_range(1, 3));
    rpat = $urandom_range(0, 1) ? kscm_pkg::SW_ANY : SW_W'($urandom_range(1, 3));
    return make_entry(keys, lpat, rpat, kscm_pkg::mode_t'($urandom_range(0, 3)),
                      $urandom_range(0, 7) != 0);
  endfunction

  // ---- action checker ----
  always @(posedge clk) begin : check_actions
    action_rec_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      actions_seen++;
      if (pending_actions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("error: unexpected action entry %0d action %0d last %0d",
                   out_res.entry_index, out_res.action, out_res.last);
      end else begin
        want = pending_actions.pop_front();
        if (out_res.entry_index !== want.entry_index || out_res.action !== want.action ||
            out_res.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("error: expected entry %0d action %0d last %0d, got %0d %0d %0d",
                     want.entry_index, want.action, want.last,
                     out_res.entry_index, out_res.action, out_res.last);
        end
      end
    end
  end

  // output stalls in random bursts
  initial begin : drive_out_ready
    int stall_left;
    stall_left = 0;
    out_res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_res.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_res.ready <= 1'b0;
      end else begin
        out_res.ready <= 1'b1;
      end
    end
  end

  // ---- tests ----
  task automatic test_disabled_entries();
    write_entry(0, make_entry(16'h0000, kscm_pkg::SW_ANY, kscm_pkg::SW_ANY,
                              kscm_pkg::MODE_REPEAT, 1'b0));
    send_snapshot(16'hFFFF, 2'd3, 2'd3, 8'hFF);
    send_snapshot(16'h0000, 2'd0, 2'd0, 8'h00);
    settle();
  endtask

  task automatic test_press_and_hold();
    write_entry(0, make_entry(16'h0001, kscm_pkg::SW_ANY, kscm_pkg::SW_ANY,
                              kscm_pkg::MODE_PRESS, 1'b1));
    write_entry(1, make_entry(16'h8000, 2'd1, kscm_pkg::SW_ANY, kscm_pkg::MODE_HOLD, 1'b1));
    write_entry(7, make_entry(16'hFFFF, kscm_pkg::SW_ANY, kscm_pkg::SW_ANY,
                              kscm_pkg::MODE_HOLD, 1'b1));
    send_snapshot(16'h8001, 2'd1, 2'd2, 8'h00);
    send_snapshot(16'h8001, 2'd1, 2'd2, 8'h00);
    send_snapshot(16'hFFFF, 2'd1, 2'd2, 8'h00);
    send_snapshot(16'h0000, 2'd1, 2'd2, 8'h00);
    send_snapshot(16'h8001, 2'd2, 2'd2, 8'h00);
    settle();
  endtask

  task automatic test_hold_repeat();
    write_entry(2, make_entry(16'h0010, kscm_pkg::SW_ANY, 2'd3, kscm_pkg::MODE_REPEAT, 1'b1));
    send_snapshot(16'h0010, 2'd1, 2'd3, 8'h00);
    send_snapshot(16'h0010, 2'd1, 2'd3, 8'h04);
    send_snapshot(16'h0010, 2'd1, 2'd3, 8'hFB);
    send_snapshot(16'h0000, 2'd1, 2'd3, 8'h00);
    settle();
  endtask

  task automatic test_toggle();
    write_entry(3, make_entry(16'h0100, 2'd2, 2'd2, kscm_pkg::MODE_TOGGLE, 1'b1));
    send_snapshot(16'h0100, 2'd2, 2'd2, 8'h00);
    send_snapshot(16'h0100, 2'd2, 2'd2, 8'h00);
    send_snapshot(16'h0000, 2'd2, 2'd2, 8'h00);
    send_snapshot(16'h0100, 2'd2, 2'd2, 8'h00);
    settle();
  endtask

  // switch value 0 only matches an any pattern
  task automatic test_switch_patterns();
    write_entry(4, make_entry(16'h0000, kscm_pkg::SW_ANY, kscm_pkg::SW_ANY,
                              kscm_pkg::MODE_PRESS, 1'b1));
    write_entry(5, make_entry(16'h0000, 2'd3, 2'd1, kscm_pkg::MODE_PRESS, 1'b1));
    write_entry(6, 23'h7FFFFF);
    send_snapshot(16'hFFFF, 2'd0, 2'd0, 8'h00);
    send_snapshot(16'hFFFF, 2'd3, 2'd1, 8'h00);
    send_snapshot(16'hFFFF, 2'd3, 2'd3, 8'h00);
    send_snapshot(16'h0000, 2'd0, 2'd1, 8'h00);
    settle();
  endtask

  // a rewrite of an entry starts it with fresh flags
  task automatic test_rewrite_clears_flags();
    send_snapshot(16'h0101, 2'd2, 2'd2, 8'h00);
    settle();
    write_entry(0, map_entries[0]);
    write_entry(3, map_entries[3]);
    write_entry(6, '0);
    send_snapshot(16'h0101, 2'd2, 2'd2, 8'h00);
    settle();
  endtask

  task automatic test_random_maps();
    logic [15:0] held;
    logic [SW_W-1:0] lsw;
    logic [SW_W-1:0] rsw;
    int pick;
    held = '0;
    lsw  = 2'd1;
    rsw  = 2'd1;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      idle_on = (phase != RANDOM_PHASES - 1);
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (phase == 0 && i == 0)
          write_entry(i, 23'h7FFFFF);
        else
          write_entry(i, random_entry());
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, MAX_ENTRIES - 1);
        case ($urandom_range(0, 9))
          0, 1, 2: held = held | map_entries[pick][LSW_LSB-1:0];
          3, 4:    held = held & ~map_entries[pick][LSW_LSB-1:0];
          5:       held = 16'($urandom);
          6:       held = '0;
          default: ;
        endcase
        if ($urandom_range(0, 3) == 0) lsw = SW_W'($urandom_range(1, 3));
        if ($urandom_range(0, 3) == 0) rsw = SW_W'($urandom_range(1, 3));
        if ($urandom_range(0, 19) == 0) lsw = kscm_pkg::SW_ANY;
        if ($urandom_range(0, 19) == 0) rsw = kscm_pkg::SW_ANY;
        send_snapshot(held, lsw, rsw, 8'($urandom_range(0, 255)));
      end
      settle();
    end
  endtask

  initial begin
    rst_n                 = 1'b0;
    idle_on               = 1'b1;
    mismatches            = 0;
    snapshots_sent        = 0;
    actions_seen          = 0;
    cfg_writes            = 0;
    entry_pressed         = '0;
    entry_toggled         = '0;
    foreach (map_entries[i]) map_entries[i] = '0;
    in_req.valid          = 1'b0;
    in_req.key_bits       = '0;
    in_req.left_sw        = '0;
    in_req.right_sw       = '0;
    in_req.scheduled_mask = '0;
    cfg_wr.valid          = 1'b0;
    cfg_wr.index          = '0;
    cfg_wr.data           = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_disabled_entries();
    test_press_and_hold();
    test_hold_repeat();
    test_toggle();
    test_switch_patterns();
    test_rewrite_clears_flags();
    test_random_maps();

    $display("covered %0d snapshots and %0d entry writes, %0d actions checked",
             snapshots_sent, cfg_writes, actions_seen);
    $display("%0d mismatches across press, hold, repeat and toggle maps", mismatches);
    if (mismatches == 0 && pending_actions.size() == 0) begin
      $display("key_switch_command_mapper_tb OK");
    end else begin
      $display("key_switch_command_mapper_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== key_switch_command_mapper.f =====
rtl/kscm_pkg.sv
rtl/kscm_if.sv
rtl/kscm_cell.sv
rtl/key_switch_command_mapper.sv
sim/key_switch_command_mapper_tb.sv
